// File: hw/rtl/fltw_pkg.sv
// Shared constants and types for the four-level page table walker.
// Depends on nothing; used by the configuration block, the RAM users and the top level.
`default_nettype none

package fltw_pkg;

   // field widths
   localparam int unsigned VPAGE_W = 36;
   localparam int unsigned FRAME_W = 40;
   localparam int unsigned FLAG_W  = 12;
   localparam int unsigned ROOT_W  = 6;
   localparam int unsigned INDEX_W = 9;
   // stored table entry: frame above the twelve flag bits
   localparam int unsigned ENTRY_W = FRAME_W + FLAG_W;

   // default number of table frames
   localparam int unsigned TABLE_PAGES_DEF = 64;

   // configuration port
   localparam int unsigned CSR_AW = 4;
   localparam int unsigned CSR_DW = 64;
   localparam logic REG_ROOT_FRAME = 1'b0;
   localparam logic REG_TABLE_BASE = 1'b1;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ABSENT   = 2'd1;
   localparam logic [1:0] ST_NO_FRAME = 2'd2;
   localparam logic [1:0] ST_BAD_PTR  = 2'd3;

   // item kinds
   localparam logic KIND_TRANSLATE = 1'b0;
   localparam logic KIND_MAP       = 1'b1;

   // configuration seen by the walker
   typedef struct packed {
      logic [ROOT_W-1:0]  root_frame;
      logic [FRAME_W-1:0] table_base_frame;
   } cfg_type;

endpackage

`default_nettype wire

// File: hw/rtl/fltw_ram.sv
// Generic single-port synchronous RAM with registered read.
// Depends on nothing.
`default_nettype none

module fltw_ram #(
   parameter int unsigned WIDTH = 52,
   parameter int unsigned DEPTH = 32768
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: hw/rtl/fltw_csr.sv
// Configuration registers (root frame, table base frame) behind an APB-style port.
// Depends on fltw_pkg.
`default_nettype none

module fltw_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [fltw_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [fltw_pkg::CSR_DW-1:0] csr_pwdata,
   output logic      [fltw_pkg::CSR_DW-1:0] csr_prdata,
   output logic                             csr_pready,
   output fltw_pkg::cfg_type                cfg
);

   logic [fltw_pkg::ROOT_W-1:0]  root_ff;
   logic [fltw_pkg::ROOT_W-1:0]  root_in;
   logic [fltw_pkg::FRAME_W-1:0] base_ff;
   logic [fltw_pkg::FRAME_W-1:0] base_in;
   logic                         wr_en;
   logic                         reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   // registers sit 8 bytes apart
   assign reg_sel    = csr_paddr[3];

   // register write decode
   always_comb begin
      root_in = root_ff;
      base_in = base_ff;
      if (wr_en) begin
         case (reg_sel)
            fltw_pkg::REG_ROOT_FRAME: root_in = csr_pwdata[fltw_pkg::ROOT_W-1:0];
            fltw_pkg::REG_TABLE_BASE: base_in = csr_pwdata[fltw_pkg::FRAME_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
         base_ff <= '0;
      end else begin
         root_ff <= root_in;
         base_ff <= base_in;
      end
   end

   // read back
   always_comb begin
      case (reg_sel)
         fltw_pkg::REG_ROOT_FRAME:
            csr_prdata = fltw_pkg::CSR_DW'(root_ff);
         fltw_pkg::REG_TABLE_BASE:
            csr_prdata = fltw_pkg::CSR_DW'(base_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   assign cfg.root_frame       = root_ff;
   assign cfg.table_base_frame = base_ff;

endmodule

`default_nettype wire

// File: hw/rtl/four_level_page_table_walker.sv
// Four-level page table walker: request/response streams, table RAM and the walk sequencer.
// Depends on fltw_pkg, fltw_ram and fltw_csr.
//
// Usage:
//   req_* carries one word per request: tuser is the kind (0 translate, 1 map), tdata the
//   virtual page, physical frame and entry flags. rsp_* returns exactly one word per
//   request: tdata the translated frame and leaf flags, tuser the status.
//   The tables live in one single-port RAM of TABLE_PAGES*512 entries. A walk issues a
//   read and evaluates it in the following cycle for each level. A map writes back the
//   levels allocated on the way during the evaluation cycle and then writes the leaf;
//   a request whose root frame lies outside the table memory skips the walk and returns
//   ST_BAD_PTR. One request is walked at a time; req_tready rises again once the result
//   has moved into the output register, so a new request is taken while a result waits.
//   If rsp_tready is held low, a finished walk waits until the output register is free.
//   After reset the block clears the table RAM, one entry a cycle, all TABLE_PAGES*512
//   entries (32768 by default), with req_tready low; configuration writes are taken
//   throughout. The user must write configuration only while the block is idle; the
//   block itself does not enforce it.
`default_nettype none

module four_level_page_table_walker #(
   parameter int unsigned TABLE_PAGES = fltw_pkg::TABLE_PAGES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // requests
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [87:0]                 req_tdata,  // virt_page, phys_frame, entry_flags
   input  wire logic                        req_tuser,  // kind
   // responses
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic      [55:0]                 rsp_tdata,  // result_frame, leaf_flags, zero pad
   output logic      [1:0]                  rsp_tuser,  // status
   // configuration
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [fltw_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [fltw_pkg::CSR_DW-1:0] csr_pwdata,
   output logic      [fltw_pkg::CSR_DW-1:0] csr_prdata,
   output logic                             csr_pready
);

   localparam int unsigned FW    = $clog2(TABLE_PAGES);
   localparam int unsigned CW    = $clog2(TABLE_PAGES + 1);
   localparam int unsigned DEPTH = TABLE_PAGES * 512;
   localparam int unsigned AW    = FW + fltw_pkg::INDEX_W;
   localparam int unsigned VW    = fltw_pkg::VPAGE_W;
   localparam int unsigned RW    = fltw_pkg::FRAME_W;
   localparam int unsigned GW    = fltw_pkg::FLAG_W;
   localparam int unsigned EW    = fltw_pkg::ENTRY_W;

   // sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_LEAF  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   fltw_pkg::cfg_type cfg;

   logic [2:0]    state_ff,  state_in;
   logic [AW-1:0] clr_ff,    clr_in;
   logic [CW-1:0] nff_ff,    nff_in;
   logic [FW-1:0] cur_ff,    cur_in;
   logic [1:0]    lvl_ff,    lvl_in;
   logic          kind_ff,   kind_in;
   logic [VW-1:0] vpage_ff,  vpage_in;
   logic [RW-1:0] pframe_ff, pframe_in;
   logic [GW-1:0] flags_ff,  flags_in;
   logic [RW-1:0] pfr_ff,    pfr_in;
   logic [GW-1:0] pfl_ff,    pfl_in;
   logic [1:0]    pst_ff,    pst_in;
   logic          rv_ff,     rv_in;
   logic [RW-1:0] rfr_ff,    rfr_in;
   logic [GW-1:0] rfl_ff,    rfl_in;
   logic [1:0]    rst_ff,    rst_in;

   logic          ram_we;
   logic          ram_re;
   logic [AW-1:0] ram_addr;
   logic [EW-1:0] ram_wdata;
   logic [EW-1:0] ram_rdata;

   logic                             req_acc;
   logic                             root_bad;
   logic [fltw_pkg::INDEX_W-1:0]     idx;
   logic [31:0]                      fa;
   logic [31:0]                      fb;
   logic                             alloc_ok;
   logic [RW-1:0]                    rel;
   logic                             ptr_ok;
   logic [EW-1:0]                    alloc_entry;
   logic [2:0]                       step_state;

   fltw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fltw_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign root_bad   = 32'(cfg.root_frame) >= 32'(TABLE_PAGES);

   // index of the current level
   always_comb begin
      case (lvl_ff)
         2'd3:    idx = vpage_ff[35:27];
         2'd2:    idx = vpage_ff[26:18];
         2'd1:    idx = vpage_ff[17:9];
         default: idx = vpage_ff[8:0];
      endcase
   end

   // frame allocation, skipping the root frame
   assign fa          = 32'(nff_ff);
   assign fb          = (fa == 32'(cfg.root_frame)) ? fa + 32'd1 : fa;
   assign alloc_ok    = fb < 32'(TABLE_PAGES);
   assign alloc_entry = {cfg.table_base_frame + RW'(fb[FW-1:0]), flags_ff};

   // pointer entry to table frame
   assign rel    = ram_rdata[EW-1:GW] - cfg.table_base_frame;
   assign ptr_ok = rel < RW'(TABLE_PAGES);

   // after level 1, a map writes the leaf straight away
   assign step_state = (lvl_ff == 2'd1 && kind_ff == fltw_pkg::KIND_MAP) ? S_LEAF : S_READ;

   // walk sequencer
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      nff_in    = nff_ff;
      cur_in    = cur_ff;
      lvl_in    = lvl_ff;
      kind_in   = kind_ff;
      vpage_in  = vpage_ff;
      pframe_in = pframe_ff;
      flags_in  = flags_ff;
      pfr_in    = pfr_ff;
      pfl_in    = pfl_ff;
      pst_in    = pst_ff;
      rv_in     = rv_ff && !rsp_tready;
      rfr_in    = rfr_ff;
      rfl_in    = rfl_ff;
      rst_in    = rst_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_addr  = {cur_ff, idx};
      ram_wdata = alloc_entry;

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               kind_in   = req_tuser;
               vpage_in  = req_tdata[35:0];
               pframe_in = req_tdata[75:36];
               flags_in  = req_tdata[87:76];
               cur_in    = FW'(cfg.root_frame);
               lvl_in    = 2'd3;
               pfr_in    = '0;
               pfl_in    = '0;
               if (root_bad) begin
                  pst_in   = fltw_pkg::ST_BAD_PTR;
                  state_in = S_DONE;
               end else begin
                  pst_in   = fltw_pkg::ST_OK;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            ram_re   = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (lvl_ff == 2'd0) begin
               // translate leaf: returned as it stands
               pfr_in   = ram_rdata[EW-1:GW];
               pfl_in   = ram_rdata[GW-1:0];
               state_in = S_DONE;
            end else if (!ram_rdata[0]) begin
               if (kind_ff == fltw_pkg::KIND_TRANSLATE) begin
                  pst_in   = fltw_pkg::ST_ABSENT;
                  state_in = S_DONE;
               end else if (!alloc_ok) begin
                  nff_in   = CW'(TABLE_PAGES);
                  pst_in   = fltw_pkg::ST_NO_FRAME;
                  state_in = S_DONE;
               end else begin
                  // allocate the missing level and write its pointer back
                  ram_we   = 1'b1;
                  nff_in   = CW'(fb + 32'd1);
                  cur_in   = fb[FW-1:0];
                  lvl_in   = lvl_ff - 2'd1;
                  state_in = step_state;
               end
            end else if (!ptr_ok) begin
               pst_in   = fltw_pkg::ST_BAD_PTR;
               state_in = S_DONE;
            end else begin
               cur_in   = rel[FW-1:0];
               lvl_in   = lvl_ff - 2'd1;
               state_in = step_state;
            end
         end
         S_LEAF: begin
            ram_we    = 1'b1;
            ram_wdata = {pframe_ff, flags_ff};
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rv_ff || rsp_tready) begin
               rv_in    = 1'b1;
               rfr_in   = pfr_ff;
               rfl_in   = pfl_ff;
               rst_in   = pst_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         nff_ff   <= CW'(1);
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         nff_ff   <= nff_in;
         rv_ff    <= rv_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      lvl_ff    <= lvl_in;
      kind_ff   <= kind_in;
      vpage_ff  <= vpage_in;
      pframe_ff <= pframe_in;
      flags_ff  <= flags_in;
      pfr_ff    <= pfr_in;
      pfl_ff    <= pfl_in;
      pst_ff    <= pst_in;
      rfr_ff    <= rfr_in;
      rfl_ff    <= rfl_in;
      rst_ff    <= rst_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {4'b0, rfl_ff, rfr_ff};
   assign rsp_tuser  = rst_ff;

   // checks
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != fltw_pkg::ST_OK |-> rsp_tdata[51:0] == 52'd0)
      else $error("faulted response carries a nonzero frame or flags");

   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("table RAM read and written in the same cycle");

   a_counter_range: assert property (@(posedge clock) disable iff (reset)
      nff_ff <= CW'(TABLE_PAGES))
      else $error("free frame counter beyond table memory");

   a_one_walk: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("request accepted while a walk is in progress");

endmodule

`default_nettype wire
